### design/fixed_cell_pool_allocator_unit_defines.svh
// Assertion macros for the fixed cell pool allocator.
// Used by fixed_cell_pool_allocator_unit.sv; expects clk and rst_n in scope.
`ifndef FIXED_CELL_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_CELL_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FCPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/fcpa_pkg.sv
// Package for the fixed cell pool allocator: field widths, codes, FSM state type.
// No dependencies.
`default_nettype none

package fcpa_pkg;

  localparam int unsigned IDX_FIELD_W = 8;
  localparam int unsigned CNT_FIELD_W = 9;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } fcpa_state_t;

endpackage

`default_nettype wire

### design/fixed_cell_pool_allocator_unit.sv
// Fixed cell pool allocator: LIFO free list of cell indexes held in one link RAM.
// Depends on fcpa_pkg and fixed_cell_pool_allocator_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall): in_req_type selects allocate or free;
//   in_cell_index names the cell to free and is ignored on allocate.
//   Result channel (out_valid/out_stall): one result per request with the
//   granted (or echoed) index, status, cells in use and the peak count.
//   Result path: a transferred request is captured with the link RAM read;
//   its execute step then loads the result register. No new request is taken
//   until then; the read must return before the free-list head can advance.
//   Reset: after rst_n is released the link RAM is initialized by a sweep of
//   all NUM_CELLS entries (entry i links to i+1); in_stall stays high meanwhile.
//   Receiver stall: the result register holds; a new request may still be
//   taken, and its execute step waits until the held result is transferred.
`default_nettype none

`include "fixed_cell_pool_allocator_unit_defines.svh"

module fixed_cell_pool_allocator_unit
  import fcpa_pkg::*;
#(
  parameter int unsigned NUM_CELLS = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_req_type,
  input  wire logic [IDX_FIELD_W-1:0] in_cell_index,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [IDX_FIELD_W-1:0]      out_granted_index,
  output logic                        out_status,
  output logic [CNT_FIELD_W-1:0]      out_cells_in_use,
  output logic [CNT_FIELD_W-1:0]      out_cells_peak
);

  localparam int unsigned IDX_W  = $clog2(NUM_CELLS);
  localparam int unsigned CNT_W  = $clog2(NUM_CELLS + 1);
  localparam int unsigned WIDE_W = 18;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_CELLS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(NUM_CELLS);
  localparam logic [WIDE_W-1:0] NUM_WIDE = WIDE_W'(NUM_CELLS);

  // entry: {link valid, link}
  logic [IDX_W:0] link_mem [NUM_CELLS];
  logic [IDX_W:0] rd_data_r;

  fcpa_state_t state_r, state_nxt;
  logic [IDX_W-1:0]       init_cnt_r, init_cnt_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic                   head_valid_r, head_valid_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic [CNT_W-1:0]       peak_r, peak_nxt;
  logic                   req_r;
  logic [IDX_FIELD_W-1:0] idx_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_FIELD_W-1:0] out_index_r, out_index_nxt;
  logic                   out_status_r, out_status_nxt;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [IDX_W:0]         mem_wd;
  logic                   rd_en;
  logic                   out_load;
  logic                   idx_in_range;
  logic [IDX_W-1:0]       idx_addr;

  assign idx_in_range = WIDE_W'(idx_r) < NUM_WIDE;
  assign idx_addr     = IDX_W'(idx_r);

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    used_nxt       = used_r;
    peak_nxt       = peak_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = init_cnt_r;
    mem_wd         = {init_cnt_r != LAST_IDX, init_cnt_r + IDX_W'(1)};
    rd_en          = 1'b0;
    out_load       = 1'b0;
    in_stall       = 1'b1;
    case (state_r)
      ST_INIT: begin
        mem_we       = 1'b1;
        init_cnt_nxt = init_cnt_r + IDX_W'(1);
        if (init_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (req_r == REQ_ALLOC) begin
            if (!head_valid_r) begin
              out_index_nxt  = '0;
              out_status_nxt = STATUS_EMPTY;
            end else begin
              out_index_nxt  = IDX_FIELD_W'(head_r);
              out_status_nxt = STATUS_OK;
              head_nxt       = rd_data_r[IDX_W-1:0];
              head_valid_nxt = rd_data_r[IDX_W];
              if (used_r < MAX_CNT) begin
                used_nxt = used_r + CNT_W'(1);
              end
              if (used_nxt > peak_r) begin
                peak_nxt = used_nxt;
              end
            end
          end else begin
            out_index_nxt  = idx_r;
            out_status_nxt = STATUS_OK;
            if (idx_in_range) begin
              mem_we         = 1'b1;
              mem_wa         = idx_addr;
              mem_wd         = {head_valid_r, head_r};
              head_nxt       = idx_addr;
              head_valid_nxt = 1'b1;
              if (used_r != '0) begin
                used_nxt = used_r - CNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      head_r       <= '0;
      head_valid_r <= 1'b1;
      used_r       <= '0;
      peak_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      used_r       <= used_nxt;
      peak_r       <= peak_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_r <= in_req_type;
      idx_r <= in_cell_index;
    end
    if (out_load) begin
      out_index_r  <= out_index_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_index_r;
  assign out_status        = out_status_r;
  assign out_cells_in_use  = CNT_FIELD_W'(used_r);
  assign out_cells_peak    = CNT_FIELD_W'(peak_r);

  `FCPA_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == ST_EXEC, "transfer did not start execute")
  `FCPA_ASSERT_NOW(a_peak_ge_used, 1'b1, peak_r >= used_r, "peak count below cells in use")
  `FCPA_ASSERT_NOW(a_used_bound, 1'b1, used_r <= MAX_CNT, "cells in use above pool size")
  `FCPA_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_index_r), "stalled result changed")

endmodule

`default_nettype wire
